/* sv/iebm_pkg.sv */
// Shared types and constants for the I2C serial EEPROM byte master.
// Used by iebm_engine and i2c_eeprom_byte_master; no dependencies.
package iebm_pkg;

  // Request kinds carried in the action field.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Slave address after reset.
  localparam logic [6:0] DEV_SEL_RESET = 7'd80;

  // Number of data bits in a byte; the acknowledge bit follows them.
  localparam logic [3:0] ACK_BIT = 4'd8;

  // One input beat, as unpacked from the stream.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] mem_address;
    logic [7:0] write_data;
    logic       sda_in;
  } iebm_item_t;

  // One result beat.
  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte_out;
    logic       nack_seen;
  } iebm_result_t;

endpackage

/* sv/iebm_engine.sv */
// Bus phase sequencer of the EEPROM byte master: holds the transaction state
// and computes one tick's result. Depends on iebm_pkg.
module iebm_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  iebm_pkg::iebm_item_t   item_i,
  input  logic [6:0]             device_select_i,
  output iebm_pkg::iebm_result_t result_o
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_DEVW,
    PH_ADDR,
    PH_DATA,
    PH_RESTART,
    PH_DEVR,
    PH_RECV,
    PH_STOP
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] bit_q, bit_d;
  logic [1:0] qtr_q, qtr_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] addr_q, addr_d;
  logic [7:0] data_q, data_d;
  logic       is_read_q, is_read_d;
  logic       nack_q, nack_d;
  logic       scl_q, scl_d;
  logic       sdah_q, sdah_d;
  logic       done;

  // Next state for one tick.
  always_comb begin
    phase_e     ph;
    phase_e     nx;
    logic [3:0] b;
    logic [1:0] q;
    logic       clk;
    logic       level;
    logic       enter;
    logic       run;

    phase_d   = phase_q;
    bit_d     = bit_q;
    qtr_d     = qtr_q;
    shift_d   = shift_q;
    addr_d    = addr_q;
    data_d    = data_q;
    is_read_d = is_read_q;
    nack_d    = nack_q;
    scl_d     = scl_q;
    sdah_d    = sdah_q;
    done      = 1'b0;
    enter     = 1'b0;
    nx        = PH_IDLE;
    level     = 1'b1;
    ph        = phase_q;
    b         = bit_q;
    q         = qtr_q;
    run       = (phase_q != PH_IDLE);

    // An idle master latches a request and runs its first tick at once.
    if (phase_q == PH_IDLE) begin
      if (item_i.action == iebm_pkg::ACT_WRITE || item_i.action == iebm_pkg::ACT_READ) begin
        addr_d    = item_i.mem_address;
        data_d    = item_i.write_data;
        is_read_d = (item_i.action == iebm_pkg::ACT_READ);
        nack_d    = 1'b0;
        phase_d   = PH_START;
        bit_d     = '0;
        qtr_d     = '0;
        ph        = PH_START;
        b         = '0;
        q         = '0;
        run       = 1'b1;
      end else begin
        scl_d  = 1'b1;
        sdah_d = 1'b1;
      end
    end

    clk = (q == 2'd1) || (q == 2'd2);

    if (run) begin
      unique case (ph)
        PH_START, PH_RESTART: begin
          scl_d  = clk;
          sdah_d = (q < 2'd2);
          if (q == 2'd3) begin
            enter = 1'b1;
            nx    = (ph == PH_START) ? PH_DEVW : PH_DEVR;
          end else begin
            qtr_d = q + 2'd1;
          end
        end
        PH_DEVW, PH_ADDR, PH_DATA, PH_DEVR, PH_RECV: begin
          if (ph != PH_RECV && b < iebm_pkg::ACK_BIT) begin
            level = shift_q[3'd7 - b[2:0]];
          end
          scl_d  = clk;
          sdah_d = level;
          // Sample the data line in the middle of the high clock.
          if (q == 2'd2) begin
            if (ph == PH_RECV) begin
              if (b < iebm_pkg::ACK_BIT) begin
                shift_d = {shift_q[6:0], item_i.sda_in};
              end
            end else if (b >= iebm_pkg::ACK_BIT && item_i.sda_in) begin
              nack_d = 1'b1;
            end
          end
          if (q == 2'd3) begin
            if (b >= iebm_pkg::ACK_BIT) begin
              enter = 1'b1;
              if (ph == PH_DEVW) begin
                nx = PH_ADDR;
              end else if (ph == PH_ADDR) begin
                nx = is_read_q ? PH_RESTART : PH_DATA;
              end else if (ph == PH_DEVR) begin
                nx = PH_RECV;
              end else begin
                nx = PH_STOP;
              end
            end else begin
              bit_d = b + 4'd1;
              qtr_d = '0;
            end
          end else begin
            qtr_d = q + 2'd1;
          end
        end
        PH_STOP: begin
          if (q >= 2'd2) begin
            scl_d   = 1'b1;
            sdah_d  = 1'b1;
            done    = 1'b1;
            phase_d = PH_IDLE;
            bit_d   = '0;
            qtr_d   = '0;
          end else begin
            scl_d  = (q == 2'd1);
            sdah_d = 1'b0;
            qtr_d  = q + 2'd1;
          end
        end
        default: begin
          scl_d   = 1'b1;
          sdah_d  = 1'b1;
          phase_d = PH_IDLE;
          bit_d   = '0;
          qtr_d   = '0;
        end
      endcase
    end

    // Entering a new phase restarts the bit counter and, for a byte phase, loads the shifter.
    if (enter) begin
      phase_d = nx;
      bit_d   = '0;
      qtr_d   = '0;
      case (nx)
        PH_DEVW: shift_d = {device_select_i, 1'b0};
        PH_DEVR: shift_d = {device_select_i, 1'b1};
        PH_ADDR: shift_d = addr_q;
        PH_DATA: shift_d = data_q;
        PH_RECV: shift_d = '0;
        default: ;
      endcase
    end
  end

  // Result of this tick, seen with the state after it.
  always_comb begin
    result_o.scl_level     = scl_d;
    result_o.sda_pull_low  = ~sdah_d;
    result_o.busy_res      = (phase_d != PH_IDLE);
    result_o.done_res      = done;
    result_o.read_byte_out = (done && is_read_d) ? shift_d : 8'd0;
    result_o.nack_seen     = nack_d;
  end

  // State registers, advanced once per processed beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_q     <= '0;
      qtr_q     <= '0;
      shift_q   <= '0;
      addr_q    <= '0;
      data_q    <= '0;
      is_read_q <= 1'b0;
      nack_q    <= 1'b0;
      scl_q     <= 1'b1;
      sdah_q    <= 1'b1;
    end else if (step_i) begin
      phase_q   <= phase_d;
      bit_q     <= bit_d;
      qtr_q     <= qtr_d;
      shift_q   <= shift_d;
      addr_q    <= addr_d;
      data_q    <= data_d;
      is_read_q <= is_read_d;
      nack_q    <= nack_d;
      scl_q     <= scl_d;
      sdah_q    <= sdah_d;
    end
  end

endmodule

/* sv/i2c_eeprom_byte_master.sv */
// I2C master for a serial EEPROM (byte write, random read), one quarter bit period per beat.
// Each beat is held in an input register, passes through the phase sequencer and is
// registered in a result register. Throughput: one beat per cycle while the result
// stream accepts beats.
// Reset (asynchronous, active low): idle bus with both lines released, flags
// cleared, device select 80, no beats held. Depends on iebm_pkg and iebm_engine.
module i2c_eeprom_byte_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: device select write.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // mem_address[7:0], write_data[15:8], sda_in[16], zeros
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // scl_level[0], sda_pull_low[1], busy_res[2],
                                      // read_byte_out[10:3], nack_seen[11], zeros
  output logic        m_axis_tlast    // done_res
);

  logic                   in_valid_q;
  iebm_pkg::iebm_item_t   in_item_q;
  logic                   out_valid_q;
  iebm_pkg::iebm_result_t out_res_q;
  iebm_pkg::iebm_result_t step_res;
  logic [6:0]             dev_sel_q;
  logic                   advance;

  // A held beat moves on when the result register is free or being drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_sel_q <= iebm_pkg::DEV_SEL_RESET;
    end else if (cfg_valid_i) begin
      dev_sel_q <= cfg_data_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.action      <= s_axis_tuser;
      in_item_q.mem_address <= s_axis_tdata[7:0];
      in_item_q.write_data  <= s_axis_tdata[15:8];
      in_item_q.sda_in      <= s_axis_tdata[16];
    end
  end

  iebm_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .item_i          (in_item_q),
    .device_select_i (dev_sel_q),
    .result_o        (step_res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_res_q.done_res;
  assign m_axis_tdata  = {4'd0, out_res_q.nack_seen, out_res_q.read_byte_out,
                          out_res_q.busy_res, out_res_q.sda_pull_low, out_res_q.scl_level};

  // A finished transaction leaves the master idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.done_res |-> !out_res_q.busy_res)
    else $error("done beat reports busy");

  // A read byte is only shown on the beat that ends a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_res_q.read_byte_out != 8'd0) |-> out_res_q.done_res)
    else $error("read byte outside done beat");

  // A held input beat that cannot move on is kept unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_item_q))
    else $error("held input beat lost or changed");

endmodule
